// ===== rtl/prws_pkg.sv =====
// ----------------------------------------------------------------------------
// prws_pkg
// Shared types, sizes and codes for the point region weight sum block.
// ----------------------------------------------------------------------------
package prws_pkg;

   localparam int MAX_BOXES   = 16;
   localparam int MAX_SPHERES = 16;

   localparam int COORD_W  = 24;
   localparam int WEIGHT_W = 32;
   localparam int SUM_W    = 37;
   localparam int RSQ_W    = 46;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int SQ_W     = 2 * COORD_W + 1;
   localparam int D2_W     = SQ_W + 1;
   localparam int BCNT_W   = $clog2(MAX_BOXES + 1);
   localparam int SCNT_W   = $clog2(MAX_SPHERES + 1);

   // request codes on the input channel
   localparam logic [1:0] REQ_ADD_BOX    = 2'd0;
   localparam logic [1:0] REQ_ADD_SPHERE = 2'd1;

   // status codes on the result channel
   localparam logic [1:0] STATUS_QUERY  = 2'd0;
   localparam logic [1:0] STATUS_STORED = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   typedef enum logic [1:0] {
      OP_BOX,
      OP_SPHERE,
      OP_QUERY
   } op_type;

   // one item as it travels along the chain
   typedef struct packed {
      logic                    valid;
      op_type                  op;
      logic                    store;
      logic [BCNT_W-1:0]       bcnt;
      logic [SCNT_W-1:0]       scnt;
      coord_type [2:0]         pa;
      coord_type [2:0]         pb;
      logic [RSQ_W-1:0]        rsq;
      weight_type              w;
      sum_type                 sum;
      logic [1:0]              status;
   } item_type;

   function automatic sum_type add_weight(sum_type s, weight_type w);
      return s + {{(SUM_W - WEIGHT_W){w[WEIGHT_W-1]}}, w};
   endfunction

endpackage

// ===== rtl/prws_req_if.sv =====
// ----------------------------------------------------------------------------
// prws_req_if
// Request channel: region adds and query points, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prws_req_if
   import prws_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   coord_type  ax;
   coord_type  ay;
   coord_type  az;
   coord_type  bx;
   coord_type  by;
   coord_type  bz;
   weight_type weight;

   modport source (output valid, req_type, ax, ay, az, bx, by, bz, weight, input ready);
   modport sink   (input valid, req_type, ax, ay, az, bx, by, bz, weight, output ready);
endinterface

// ===== rtl/prws_rsp_if.sv =====
// ----------------------------------------------------------------------------
// prws_rsp_if
// Response channel: weighted sum and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface prws_rsp_if
   import prws_pkg::*;
();
   logic       valid;
   logic       ready;
   sum_type    weighted_sum;
   logic [1:0] status;

   modport source (output valid, weighted_sum, status, input ready);
   modport sink   (input valid, weighted_sum, status, output ready);
endinterface

// ===== rtl/prws_entry.sv =====
// ----------------------------------------------------------------------------
// prws_entry
// Decodes a request, keeps the table fill counts, orders box corners and
// squares the sphere radius, then launches the item into the cell chain.
// ----------------------------------------------------------------------------
module prws_entry
   import prws_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   prws_req_if.sink req,
   output item_type item_out
);

   item_type                      item_ff, item_in;
   logic [BCNT_W-1:0]             bcnt_ff, bcnt_in;
   logic [SCNT_W-1:0]             scnt_ff, scnt_in;
   logic                          accept;
   logic signed [2*COORD_W-1:0]   rprod;

   assign req.ready = adv;
   assign accept    = req.valid && adv;
   assign item_out  = item_ff;

   // decode and prepare the item
   always_comb begin
      coord_type a_pt [3];
      coord_type b_pt [3];
      a_pt[0] = req.ax;
      a_pt[1] = req.ay;
      a_pt[2] = req.az;
      b_pt[0] = req.bx;
      b_pt[1] = req.by;
      b_pt[2] = req.bz;

      rprod = req.bx * req.bx;

      item_in        = '0;
      item_in.valid  = req.valid;
      item_in.bcnt   = bcnt_ff;
      item_in.scnt   = scnt_ff;
      item_in.w      = req.weight;
      item_in.rsq    = (rprod[2*COORD_W-1:RSQ_W] != '0) ? '1 : rprod[RSQ_W-1:0];
      bcnt_in        = bcnt_ff;
      scnt_in        = scnt_ff;

      for (int k = 0; k < 3; k++) begin
         item_in.pa[k] = a_pt[k];
         item_in.pb[k] = b_pt[k];
      end

      unique case (req.req_type)
         REQ_ADD_BOX: begin
            item_in.op = OP_BOX;
            for (int k = 0; k < 3; k++) begin
               if (a_pt[k] > b_pt[k]) begin
                  item_in.pa[k] = b_pt[k];
                  item_in.pb[k] = a_pt[k];
               end
            end
            if (bcnt_ff == BCNT_W'(MAX_BOXES)) begin
               item_in.status = STATUS_FULL;
            end else begin
               item_in.store  = 1'b1;
               item_in.status = STATUS_STORED;
               if (accept) begin
                  bcnt_in = bcnt_ff + BCNT_W'(1);
               end
            end
         end
         REQ_ADD_SPHERE: begin
            item_in.op = OP_SPHERE;
            if (scnt_ff == SCNT_W'(MAX_SPHERES)) begin
               item_in.status = STATUS_FULL;
            end else begin
               item_in.store  = 1'b1;
               item_in.status = STATUS_STORED;
               if (accept) begin
                  scnt_in = scnt_ff + SCNT_W'(1);
               end
            end
         end
         default: begin
            item_in.op     = OP_QUERY;
            item_in.status = STATUS_QUERY;
         end
      endcase
   end

   // fill counts and launch register
   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff       <= '0;
         scnt_ff       <= '0;
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         bcnt_ff <= bcnt_in;
         scnt_ff <= scnt_in;
         item_ff <= item_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      bcnt_ff <= BCNT_W'(MAX_BOXES) && scnt_ff <= SCNT_W'(MAX_SPHERES))
      else $error("fill count beyond table size");

   assert property (@(posedge clock) disable iff (reset)
      accept && req.req_type == REQ_ADD_BOX && bcnt_ff != BCNT_W'(MAX_BOXES)
      |=> bcnt_ff == $past(bcnt_ff) + BCNT_W'(1))
      else $error("box add did not advance box count");

   assert property (@(posedge clock) disable iff (reset)
      item_ff.valid && item_ff.status == STATUS_FULL |-> !item_ff.store)
      else $error("dropped add marked for store");
`endif

endmodule

// ===== rtl/prws_box_cell.sv =====
// ----------------------------------------------------------------------------
// prws_box_cell
// One box slot of the chain: stores its box on the matching add and adds
// its weight to a passing query whose point lies inside the bounds.
// ----------------------------------------------------------------------------
module prws_box_cell
   import prws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [BCNT_W-1:0] cell_idx,
   input  item_type          item_i,
   output item_type          item_o
);

   item_type        item_ff, item_in;
   coord_type [2:0] lo_ff;
   coord_type [2:0] hi_ff;
   weight_type      w_ff;
   logic            hit;

   assign item_o = item_ff;

   // containment test, bounds inclusive
   always_comb begin
      hit = item_i.op == OP_QUERY && cell_idx < item_i.bcnt;
      for (int k = 0; k < 3; k++) begin
         if (item_i.pa[k] < lo_ff[k] || item_i.pa[k] > hi_ff[k]) begin
            hit = 1'b0;
         end
      end
      item_in = item_i;
      if (hit) begin
         item_in.sum = add_weight(item_i.sum, w_ff);
      end
   end

   // box storage, written by the add aimed at this slot
   always_ff @(posedge clock) begin
      if (adv && item_i.valid && item_i.op == OP_BOX && item_i.store &&
          item_i.bcnt == cell_idx) begin
         lo_ff <= item_i.pa;
         hi_ff <= item_i.pb;
         w_ff  <= item_i.w;
      end
   end

   // chain register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (adv) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/prws_sphere_cell.sv =====
// ----------------------------------------------------------------------------
// prws_sphere_cell
// One sphere slot of the chain, two stages: squares of the axis distances,
// then sum and strict compare. A hit weight is handed on and added to the
// running sum in the next slot's first stage.
// ----------------------------------------------------------------------------
module prws_sphere_cell
   import prws_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [SCNT_W-1:0] cell_idx,
   input  item_type          item_i,
   input  weight_type        pend_i,
   output item_type          item_o,
   output weight_type        pend_o
);

   item_type          a_item_ff, a_item_in;
   item_type          b_item_ff;
   logic [SQ_W-1:0]   sq_ff [3];
   logic [SQ_W-1:0]   sq_in [3];
   logic              en_ff, en_in;
   weight_type        pend_ff, pend_in;
   coord_type [2:0]   c_ff;
   logic [RSQ_W-1:0]  rsq_ff;
   weight_type        w_ff;
   logic [D2_W-1:0]   d2;

   assign item_o = b_item_ff;
   assign pend_o = pend_ff;

   // first stage: settle the pending weight, square the distances
   always_comb begin
      logic signed [DIFF_W-1:0]   d;
      logic signed [2*DIFF_W-1:0] p;
      a_item_in     = item_i;
      a_item_in.sum = add_weight(item_i.sum, pend_i);
      en_in         = item_i.op == OP_QUERY && cell_idx < item_i.scnt;
      for (int k = 0; k < 3; k++) begin
         d        = {item_i.pa[k][COORD_W-1], item_i.pa[k]} -
                    {c_ff[k][COORD_W-1], c_ff[k]};
         p        = d * d;
         sq_in[k] = p[SQ_W-1:0];
      end
   end

   // second stage: strict inside test
   always_comb begin
      d2 = D2_W'(sq_ff[0]) + D2_W'(sq_ff[1]) + D2_W'(sq_ff[2]);
      if (en_ff && d2 < D2_W'(rsq_ff)) begin
         pend_in = w_ff;
      end else begin
         pend_in = '0;
      end
   end

   // sphere storage, written by the add aimed at this slot
   always_ff @(posedge clock) begin
      if (adv && item_i.valid && item_i.op == OP_SPHERE && item_i.store &&
          item_i.scnt == cell_idx) begin
         c_ff   <= item_i.pa;
         rsq_ff <= item_i.rsq;
         w_ff   <= item_i.w;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_item_ff.valid <= 1'b0;
         b_item_ff.valid <= 1'b0;
      end else if (adv) begin
         a_item_ff <= a_item_in;
         sq_ff     <= sq_in;
         en_ff     <= en_in;
         b_item_ff <= a_item_ff;
         pend_ff   <= pend_in;
      end
   end

endmodule

// ===== rtl/point_region_weight_sum.sv =====
// ----------------------------------------------------------------------------
// point_region_weight_sum
// Weighted box and sphere membership: a chain of box slots and sphere slots
// that a query point walks through, collecting the weights of the regions
// that hold it.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | req_type, ax, ay, az, bx, by, bz, weight
//  rsp     | out | valid / ready | weighted_sum, status
//
//  one item enters per cycle while the chain advances; each item passes the
//  entry register, one stage per box slot, two per sphere slot, then output
//  the whole chain moves as one: a result not taken holds every stage and
//  req.ready drops until the output register frees
//  reset clears the fill counts and stage valid bits; slot contents are not
//  cleared, a slot at or beyond the count never contributes
// ----------------------------------------------------------------------------
module point_region_weight_sum
   import prws_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   prws_req_if.sink   req,
   prws_rsp_if.source rsp
);

   logic       adv;
   item_type   box_chain [MAX_BOXES + 1];
   item_type   sph_chain [MAX_SPHERES + 1];
   weight_type pend_chain [MAX_SPHERES + 1];
   logic       out_valid_ff;
   sum_type    out_sum_ff;
   logic [1:0] out_status_ff;
   item_type   last_item;

   // global advance: output register empty or being taken
   assign adv = !out_valid_ff || rsp.ready;

   // decode and launch
   prws_entry u_entry (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .req      (req),
      .item_out (box_chain[0])
   );

   // box slots
   for (genvar g = 0; g < MAX_BOXES; g++) begin : g_box
      prws_box_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_idx (BCNT_W'(g)),
         .item_i   (box_chain[g]),
         .item_o   (box_chain[g+1])
      );
   end

   assign sph_chain[0]  = box_chain[MAX_BOXES];
   assign pend_chain[0] = '0;

   // sphere slots
   for (genvar g = 0; g < MAX_SPHERES; g++) begin : g_sph
      prws_sphere_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .cell_idx (SCNT_W'(g)),
         .item_i   (sph_chain[g]),
         .pend_i   (pend_chain[g]),
         .item_o   (sph_chain[g+1]),
         .pend_o   (pend_chain[g+1])
      );
   end

   assign last_item = sph_chain[MAX_SPHERES];

   // output register, last pending weight folded in
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff  <= last_item.valid;
         out_sum_ff    <= add_weight(last_item.sum, pend_chain[MAX_SPHERES]);
         out_status_ff <= last_item.status;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.weighted_sum = out_sum_ff;
   assign rsp.status       = out_status_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("item accepted while chain stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != STATUS_QUERY |-> rsp.weighted_sum == '0)
      else $error("add item answered with nonzero sum");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status == STATUS_QUERY || rsp.status == STATUS_STORED ||
                    rsp.status == STATUS_FULL)
      else $error("undefined status on result");
`endif

endmodule
